@@ rtl/core/nfsa_pkg.sv @@
// Shared types and constants for the next-fit slot allocator.
`timescale 1ns / 1ps

package nfsa_pkg;

   localparam int MAX_SLOTS  = 64;
   localparam int SLOT_W     = $clog2(MAX_SLOTS);
   localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
   localparam int CSR_ADDR_W = 3;

   // Register index, taken from the word-aligned part of the address.
   localparam logic REG_SLOTS_IN_USE = 1'b0;

   localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(MAX_SLOTS);

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_FILL  = 2'd3
   } op_type;

   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_FREE  = 6'b001000,
      ST_SWEEP = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic              granted;
      logic [SLOT_W-1:0] slot;
      logic              error;
      logic [CNT_W-1:0]  active_count;
   } res_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic              wr_data;
      logic [SLOT_W-1:0] rd_addr;
   } mem_req_type;

endpackage

@@ rtl/core/next_fit_slot_allocator.sv @@
// Top level of the next-fit slot allocator: CSR, flag RAM, sequencer, response register.
`timescale 1ns / 1ps

// Pool of up to 64 slots with a busy flag each, kept in a one-port-write,
// one-port-read flag RAM. A request word carries the operation in tuser and
// the slot to free in tdata; every request yields exactly one response word.
// Allocate scans circularly from the search pointer, one slot per cycle
// through the RAM's registered read, checking slots until an idle one turns
// up or the whole pool has been seen. Clear and fill rewrite all 64 RAM
// entries, one per cycle. After reset the block runs a clearing pass over
// all 64 RAM entries with req_tready low; the CSR port works throughout.
// The slots_in_use register (address 0) selects the pool size; 0 acts as 1
// and values above 64 act as 64. Write it only while idle.
// A finished response waits in its own register, so the next request is
// taken while the previous response is still pending.
module next_fit_slot_allocator import nfsa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [5:0] slot_index, [7:6] zero
   input  logic [1:0]            req_tuser,   // [1:0] operation
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [0] granted, [6:1] slot, [7] error,
                                              // [14:8] active_count, [15] zero
   // APB-style CSR port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [CNT_W-1:0] slots_ff, slots_in;
   logic [CNT_W-1:0] pool_size;
   logic             csr_wr;

   mem_req_type      mem_req;
   logic [0:0]       rd_data;
   logic             res_valid;
   res_type          res;

   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_ff, rsp_in;
   logic             rsp_free;

   // CSR: single register, no wait states
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_SLOTS_IN_USE) ? {{(32 - CNT_W){1'b0}}, slots_ff}
                                                           : '0;

   always_comb begin
      slots_in = slots_ff;
      if (csr_wr && (csr_paddr[2] == REG_SLOTS_IN_USE)) begin
         slots_in = csr_pwdata[CNT_W-1:0];
      end
   end

   // clamp the register to 1..MAX_SLOTS
   always_comb begin
      priority if (slots_ff == '0) begin
         pool_size = CNT_W'(1);
      end else if (slots_ff > CNT_W'(MAX_SLOTS)) begin
         pool_size = CNT_W'(MAX_SLOTS);
      end else begin
         pool_size = slots_ff;
      end
   end

   nfsa_flag_ram #(
      .DEPTH (MAX_SLOTS),
      .WIDTH (1)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   nfsa_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .pool_size (pool_size),
      .req_valid (req_tvalid),
      .req_op    (op_type'(req_tuser)),
      .req_idx   (req_tdata[SLOT_W-1:0]),
      .req_ready (req_tready),
      .rd_data   (rd_data[0]),
      .mem_req   (mem_req),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (rsp_free)
   );

   // response register: load a finished result whenever the slot is free
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff     <= SLOTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         slots_ff     <= slots_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.active_count, rsp_ff.error, rsp_ff.slot,
                        rsp_ff.granted};

   // busy count can never pass the number of RAM entries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.active_count <= CNT_W'(MAX_SLOTS)))
      else $error("active_count above pool capacity");

   // a grant is never an error and always names a slot inside the pool
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.granted) |->
         (!rsp_ff.error && ({1'b0, rsp_ff.slot} < pool_size)))
      else $error("granted response with error or slot outside pool");

   // req_tready is low as reset falls and the post-reset clearing pass starts
   a_init_block: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready)
      else $error("request accepted during clearing pass");

   // a pending result is never dropped while the response is stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (res_valid && rsp_valid_ff && !rsp_tready) |=> res_valid)
      else $error("result lost while response stalled");

endmodule

@@ rtl/core/nfsa_flag_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module nfsa_flag_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/nfsa_engine.sv @@
// Sequencer: scans, frees, sweeps the busy-flag RAM and keeps pointer and count.
`timescale 1ns / 1ps

module nfsa_engine import nfsa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_W-1:0]  pool_size,
   input  logic              req_valid,
   input  op_type            req_op,
   input  logic [SLOT_W-1:0] req_idx,
   output logic              req_ready,
   input  logic              rd_data,
   output mem_req_type       mem_req,
   output logic              res_valid,
   output res_type           res,
   input  logic              res_take
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] chk_ff, chk_in;
   logic [CNT_W-1:0]  tries_ff, tries_in;
   logic [SLOT_W-1:0] sweep_ff, sweep_in;
   res_type           res_ff, res_in;

   logic [SLOT_W-1:0] start_slot;
   logic [CNT_W-1:0]  chk_inc;
   logic [SLOT_W-1:0] chk_next;

   assign start_slot = ({1'b0, ptr_ff} < pool_size) ? ptr_ff : '0;
   assign chk_inc    = {1'b0, chk_ff} + CNT_W'(1);
   assign chk_next   = (chk_inc == pool_size) ? '0 : chk_inc[SLOT_W-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      ptr_in   = ptr_ff;
      count_in = count_ff;
      chk_in   = chk_ff;
      tries_in = tries_ff;
      sweep_in = sweep_ff;
      res_in   = res_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = sweep_ff;
      mem_req.wr_data = 1'b0;
      mem_req.rd_addr = chk_ff;

      unique case (state_ff)
         ST_INIT: begin
            // clear every flag after reset, one entry a cycle
            mem_req.wr_en = 1'b1;
            if (sweep_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + SLOT_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_op;
               idx_in = req_idx;
               unique case (req_op)
                  OP_ALLOC: begin
                     mem_req.rd_addr = start_slot;
                     chk_in          = start_slot;
                     tries_in        = '0;
                     state_in        = ST_SCAN;
                  end
                  OP_FREE: begin
                     mem_req.rd_addr = req_idx;
                     state_in        = ST_FREE;
                  end
                  OP_CLEAR, OP_FILL: begin
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // rd_data holds the flag of chk_ff
            if (!rd_data) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = chk_ff;
               mem_req.wr_data = 1'b1;
               ptr_in          = chk_next;
               count_in        = count_ff + CNT_W'(1);
               res_in          = '{granted: 1'b1, slot: chk_ff, error: 1'b0,
                                   active_count: count_ff + CNT_W'(1)};
               state_in        = ST_DONE;
            end else if (tries_ff == pool_size - CNT_W'(1)) begin
               res_in   = '{granted: 1'b0, slot: '0, error: 1'b1,
                            active_count: count_ff};
               state_in = ST_DONE;
            end else begin
               mem_req.rd_addr = chk_next;
               chk_in          = chk_next;
               tries_in        = tries_ff + CNT_W'(1);
            end
         end
         ST_FREE: begin
            if (({1'b0, idx_ff} < pool_size) && rd_data) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = idx_ff;
               mem_req.wr_data = 1'b0;
               count_in        = (count_ff != '0) ? count_ff - CNT_W'(1) : count_ff;
               res_in          = '{granted: 1'b0, slot: '0, error: 1'b0,
                                   active_count: count_in};
            end else begin
               res_in = '{granted: 1'b0, slot: '0, error: 1'b1,
                          active_count: count_ff};
            end
            state_in = ST_DONE;
         end
         ST_SWEEP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = (op_ff == OP_FILL) && ({1'b0, sweep_ff} < pool_size);
            if (sweep_ff == LAST_SLOT) begin
               count_in = (op_ff == OP_FILL) ? pool_size : '0;
               ptr_in   = '0;
               res_in   = '{granted: 1'b0, slot: '0, error: 1'b0,
                            active_count: count_in};
               state_in = ST_DONE;
            end else begin
               sweep_in = sweep_ff + SLOT_W'(1);
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ptr_ff   <= '0;
         count_ff <= '0;
         sweep_ff <= '0;
         op_ff    <= OP_ALLOC;
         tries_ff <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
         sweep_ff <= sweep_in;
         op_ff    <= op_in;
         tries_ff <= tries_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      chk_ff <= chk_in;
      res_ff <= res_in;
   end

endmodule
